// File: sv/iocit_pkg.sv
package iocit_pkg;

  localparam int NumTimers = 5;

  typedef enum logic [2:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_TICK   = 3'd2,
    KIND_SENSOR = 3'd3,
    KIND_BIT7   = 3'd4
  } kind_t;

  localparam logic [3:0] AddrPins    = 4'd1;
  localparam logic [3:0] AddrVector  = 4'd2;
  localparam logic [3:0] AddrStatus  = 4'd3;
  localparam logic [3:0] AddrCommand = 4'd4;
  localparam logic [3:0] AddrRate    = 4'd5;
  localparam logic [3:0] AddrPort    = 4'd7;
  localparam logic [3:0] AddrMask    = 4'd8;
  localparam logic [3:0] AddrTimer0  = 4'd9;
  localparam logic [3:0] AddrTimer4  = 4'd13;

  localparam logic [7:0] VectorBase  = 8'hc7;
  localparam logic [7:0] StatusConst = 8'h10;
  localparam logic [7:0] SensorBit   = 8'h04;
  localparam logic [7:0] Bit7Bit     = 8'h80;

  // queued item between the front and back parts
  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] address;
    logic [7:0] value;
    logic [7:0] pio_pins;
  } item_t;

  function automatic logic [7:0] timer_bit(input logic [2:0] t);
    case (t)
      3'd0:    timer_bit = 8'h01;
      3'd1:    timer_bit = 8'h02;
      3'd2:    timer_bit = 8'h08;
      3'd3:    timer_bit = 8'h40;
      default: timer_bit = 8'h80;
    endcase
  endfunction

endpackage

// File: sv/io_controller_interrupt_timers_top.sv
// channel   direction  beat fields
// in        input      kind, address, value, pio_pins
// out       output     read_data, int_event, int_request, int_vector, pio_write,
//                      pio_data, last
// a read, write or level event yields one beat; a tick walks the
// five timers one per cycle, emitting one beat per expiry
// a two-entry queue parts the front from the back; results sit in one
// output register, and a tick walk pauses while it is stalled
// rst is synchronous and returns the state registers and timers to zero; the output data fields are not reset
module io_controller_interrupt_timers_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [3:0] address,
  input  logic [7:0] value,
  input  logic [7:0] pio_pins,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       int_event,
  output logic       int_request,
  output logic [7:0] int_vector,
  output logic       pio_write,
  output logic [7:0] pio_data,
  output logic       last
);
  iocit_pkg::item_t in_item, q_item;
  logic q_valid, q_take;

  assign in_item = '{kind: kind, address: address, value: value, pio_pins: pio_pins};

  iocit_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(q_valid), .out_take(q_take), .out_item(q_item)
  );

  iocit_back u_back (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_take(q_take), .in_item(q_item),
    .valid(out_valid), .stall(out_stall),
    .read_data(read_data), .int_event(int_event), .int_request(int_request),
    .int_vector(int_vector), .pio_write(pio_write), .pio_data(pio_data),
    .last(last)
  );
endmodule

// File: sv/iocit_queue.sv
module iocit_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  iocit_pkg::item_t   in_item,
  output logic               out_valid,
  input  logic               out_take,
  output iocit_pkg::item_t   out_item
);
  // two-entry queue; drops unknown kinds at the front
  iocit_pkg::item_t mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop, known;

  assign known     = in_item.kind <= iocit_pkg::KIND_BIT7;
  assign in_stall  = count == 2'd2;
  assign push      = in_valid && !in_stall && known;
  assign out_valid = count != 2'd0;
  assign pop       = out_valid && out_take;
  assign out_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_item;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: sv/iocit_back.sv
module iocit_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_take,
  input  iocit_pkg::item_t in_item,
  output logic             valid,
  input  logic             stall,
  output logic [7:0]       read_data,
  output logic             int_event,
  output logic             int_request,
  output logic [7:0]       int_vector,
  output logic             pio_write,
  output logic [7:0]       pio_data,
  output logic             last
);
  localparam int N = iocit_pkg::NumTimers;

  logic [7:0] pending_bits, mask_bits, vector_latch, rate_register, output_port;
  logic [2:0] command_flags;
  logic       bit7_level, sensor_level;
  logic [7:0] reload_value [N];
  logic [7:0] remaining_count [N];
  logic [N-1:0] timer_running;

  // tick walk: timer index under work, one timer per cycle while the output is free
  logic       ticking;
  logic [2:0] tidx;

  logic out_free, step;
  assign out_free = !valid || !stall;

  logic [2:0] cur_t;
  assign cur_t = ticking ? tidx : 3'd0;

  logic tick_mode;
  assign tick_mode = ticking || in_item.kind == iocit_pkg::KIND_TICK;

  logic [7:0] rd;
  always_comb begin
    case (in_item.address)
      iocit_pkg::AddrPins:    rd = in_item.pio_pins;
      iocit_pkg::AddrVector:  rd = vector_latch;
      iocit_pkg::AddrStatus:  rd = iocit_pkg::StatusConst;
      iocit_pkg::AddrCommand: rd = {4'd0, command_flags, 1'b0};
      iocit_pkg::AddrRate:    rd = rate_register;
      iocit_pkg::AddrMask:    rd = mask_bits;
      default:                rd = 8'd0;
    endcase
  end

  logic is_timer_wr;
  logic [2:0] wt;
  assign is_timer_wr = in_item.address >= iocit_pkg::AddrTimer0 &&
                       in_item.address <= iocit_pkg::AddrTimer4;
  assign wt = 3'(in_item.address - iocit_pkg::AddrTimer0);

  logic [2:0] fire_t;
  assign fire_t = tick_mode ? cur_t : wt;

  logic t_run, t_exp, t_last;
  assign t_run  = timer_running[cur_t];
  assign t_exp  = t_run && remaining_count[cur_t] <= 8'd1;
  logic [N-1:0] later;
  always_comb begin
    for (int i = 0; i < N; i++)
      later[i] = (3'(i) > cur_t) && timer_running[i] && remaining_count[i] <= 8'd1;
  end
  assign t_last = later == '0;

  // fielding on a given pending byte
  logic [7:0] pend_in, live, pend_out, vec;
  logic       req;
  logic [2:0] lvl;
  always_comb begin
    live = pend_in & mask_bits;
    lvl = 3'd0;
    for (int i = 7; i >= 0; i--)
      if (live[i]) lvl = 3'(i);
    req = live != 8'd0;
    vec = iocit_pkg::VectorBase + {2'd0, lvl, 3'd0};
    pend_out = req ? (pend_in & ~(8'd1 << lvl)) : pend_in;
  end

  logic fire_src;
  logic [7:0] fire_mask;
  always_comb begin
    fire_mask = iocit_pkg::timer_bit(fire_t);
    fire_src = !(fire_t == 3'd4 && command_flags[1]);
    pend_in = pending_bits;
    if (tick_mode || (in_item.kind == iocit_pkg::KIND_WRITE && is_timer_wr))
      pend_in = fire_src ? (pending_bits | fire_mask) : pending_bits;
    else if (in_item.kind == iocit_pkg::KIND_SENSOR)
      pend_in = (!sensor_level && in_item.value != 8'd0) ?
                (pending_bits | iocit_pkg::SensorBit) : pending_bits;
    else if (in_item.kind == iocit_pkg::KIND_BIT7)
      pend_in = (!bit7_level && in_item.value != 8'd0 && command_flags[1]) ?
                (pending_bits | iocit_pkg::Bit7Bit) : pending_bits;
  end

  assign step = in_valid && out_free;
  assign in_take = step && (!ticking ? in_item.kind != iocit_pkg::KIND_TICK
                                     : tidx == 3'(N - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      ticking <= 1'b0;
      tidx <= 3'd0;
      pending_bits <= '0; mask_bits <= '0; vector_latch <= '0;
      rate_register <= '0; output_port <= '0; command_flags <= '0;
      bit7_level <= 1'b0; sensor_level <= 1'b0;
      timer_running <= '0;
      for (int i = 0; i < N; i++) begin
        reload_value[i] <= '0;
        remaining_count[i] <= '0;
      end
    end else begin
      if (out_free) valid <= 1'b0;
      if (step) begin
        read_data <= 8'd0; int_event <= 1'b0; int_request <= 1'b0;
        int_vector <= 8'd0; pio_write <= 1'b0; last <= 1'b1;
        pio_data <= output_port;
        if (tick_mode) begin
          if (t_run) begin
            if (t_exp) begin
              remaining_count[cur_t] <= reload_value[cur_t];
              if (reload_value[cur_t] == 8'd0) timer_running[cur_t] <= 1'b0;
              pending_bits <= pend_out;
              if (req) vector_latch <= vec;
              valid <= 1'b1;
              int_event <= 1'b1; int_request <= req;
              int_vector <= req ? vec : 8'd0;
              last <= t_last;
            end else begin
              remaining_count[cur_t] <= remaining_count[cur_t] - 8'd1;
            end
          end
          ticking <= cur_t != 3'(N - 1);
          tidx <= cur_t + 3'd1;
        end else begin
          valid <= 1'b1;
          unique case (in_item.kind)
            iocit_pkg::KIND_READ: read_data <= rd;
            iocit_pkg::KIND_WRITE: begin
              if (is_timer_wr) begin
                reload_value[wt] <= in_item.value;
                if (in_item.value != 8'd0) begin
                  remaining_count[wt] <= in_item.value;
                  timer_running[wt] <= 1'b1;
                end else begin
                  timer_running[wt] <= 1'b0;
                  remaining_count[wt] <= 8'd0;
                  pending_bits <= pend_out;
                  if (req) vector_latch <= vec;
                  int_event <= 1'b1; int_request <= req;
                  int_vector <= req ? vec : 8'd0;
                end
              end else begin
                case (in_item.address)
                  iocit_pkg::AddrCommand: begin
                    if (in_item.value[0]) begin
                      pending_bits <= '0; rate_register <= '0; output_port <= '0;
                      bit7_level <= 1'b0; timer_running <= '0;
                      for (int i = 0; i < N; i++) begin
                        reload_value[i] <= '0;
                        remaining_count[i] <= '0;
                      end
                      pio_data <= 8'd0;
                    end
                    command_flags <= in_item.value[3:1];
                  end
                  iocit_pkg::AddrRate: rate_register <= in_item.value;
                  iocit_pkg::AddrPort: begin
                    output_port <= in_item.value;
                    pio_data <= in_item.value;
                    pio_write <= 1'b1;
                  end
                  iocit_pkg::AddrMask: mask_bits <= in_item.value;
                  default: ;
                endcase
              end
            end
            iocit_pkg::KIND_SENSOR, iocit_pkg::KIND_BIT7: begin
              if (in_item.kind == iocit_pkg::KIND_SENSOR)
                sensor_level <= in_item.value != 8'd0;
              else
                bit7_level <= in_item.value != 8'd0;
              pending_bits <= pend_out;
              if (req) vector_latch <= vec;
              int_event <= 1'b1; int_request <= req;
              int_vector <= req ? vec : 8'd0;
            end
            default: valid <= 1'b0;
          endcase
        end
      end
    end
  end
endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  typedef struct packed {
    logic [7:0] read_data;
    logic       int_event;
    logic       int_request;
    logic [7:0] int_vector;
    logic       pio_write;
    logic [7:0] pio_data;
    logic       last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = '0;
  logic [3:0] address = '0;
  logic [7:0] value = '0;
  logic [7:0] pio_pins = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] read_data;
  logic int_event, int_request, pio_write, last;
  logic [7:0] int_vector, pio_data;

  io_controller_interrupt_timers_top dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [7:0] pend, mask, vlatch, rate, port;
  logic [2:0] cmd;
  logic       b7_lvl, sens_lvl;
  logic [7:0] reload [iocit_pkg::NumTimers];
  logic [7:0] count [iocit_pkg::NumTimers];
  logic       running [iocit_pkg::NumTimers];

  iocit_pkg::item_t items_q[$];
  beat_t expected_q[$];
  int errors = 0;
  int stall_count = 0;
  int watchdog = 0;

  function automatic logic [7:0] pend_bit(int t);
    case (t)
      0: pend_bit = 8'h01;
      1: pend_bit = 8'h02;
      2: pend_bit = 8'h08;
      3: pend_bit = 8'h40;
      default: pend_bit = 8'h80;
    endcase
  endfunction

  task automatic clear_soft();
    pend = '0; rate = '0; port = '0; b7_lvl = 1'b0;
    for (int t = 0; t < iocit_pkg::NumTimers; t++) begin
      reload[t] = '0; count[t] = '0; running[t] = 1'b0;
    end
  endtask

  task automatic timer_expire(int t);
    if (!(t == 4 && cmd[1])) pend |= pend_bit(t);
  endtask

  task automatic push_plain(logic [7:0] rd, logic pw);
    beat_t b;
    b = '0; b.read_data = rd; b.pio_write = pw; b.pio_data = port;
    expected_q.push_back(b);
  endtask

  // lowest unmasked pending level is cleared and reported
  task automatic push_fielding();
    beat_t b;
    logic [7:0] live;
    b = '0; b.int_event = 1'b1;
    live = pend & mask;
    for (int l = 0; l < 8; l++) begin
      if (live[l]) begin
        pend[l] = 1'b0;
        vlatch = iocit_pkg::VectorBase + 8'(8 * l);
        b.int_request = 1'b1;
        b.int_vector = vlatch;
        break;
      end
    end
    b.pio_data = port;
    expected_q.push_back(b);
  endtask

  task automatic predict(iocit_pkg::item_t it);
    int n0, t;
    logic [7:0] rd;
    n0 = expected_q.size();
    case (it.kind)
      iocit_pkg::KIND_READ: begin
        case (it.address)
          iocit_pkg::AddrPins:    rd = it.pio_pins;
          iocit_pkg::AddrVector:  rd = vlatch;
          iocit_pkg::AddrStatus:  rd = iocit_pkg::StatusConst;
          iocit_pkg::AddrCommand: rd = {4'b0, cmd, 1'b0};
          iocit_pkg::AddrRate:    rd = rate;
          iocit_pkg::AddrMask:    rd = mask;
          default:                rd = 8'd0;
        endcase
        push_plain(rd, 1'b0);
      end
      iocit_pkg::KIND_WRITE: begin
        if (it.address >= iocit_pkg::AddrTimer0 && it.address <= iocit_pkg::AddrTimer4) begin
          t = int'(it.address - iocit_pkg::AddrTimer0);
          reload[t] = it.value;
          if (it.value != 8'd0) begin
            count[t] = it.value; running[t] = 1'b1;
            push_plain(8'h00, 1'b0);
          end else begin
            timer_expire(t);
            push_fielding();
            running[t] = 1'b0; count[t] = '0;
          end
        end else begin
          case (it.address)
            iocit_pkg::AddrCommand: begin
              if (it.value[0]) clear_soft();
              cmd = it.value[3:1];
            end
            iocit_pkg::AddrRate: rate = it.value;
            iocit_pkg::AddrPort: port = it.value;
            iocit_pkg::AddrMask: mask = it.value;
            default: ;
          endcase
          push_plain(8'h00, it.address == iocit_pkg::AddrPort);
        end
      end
      iocit_pkg::KIND_TICK: begin
        for (t = 0; t < iocit_pkg::NumTimers; t++) begin
          if (!running[t]) continue;
          if (count[t] > 8'd1) begin
            count[t]--;
            continue;
          end
          count[t] = reload[t];
          if (reload[t] == 8'd0) running[t] = 1'b0;
          timer_expire(t);
          push_fielding();
        end
      end
      iocit_pkg::KIND_SENSOR: begin
        if (!sens_lvl && it.value != 8'd0) pend |= iocit_pkg::SensorBit;
        sens_lvl = it.value != 8'd0;
        push_fielding();
      end
      iocit_pkg::KIND_BIT7: begin
        if (!b7_lvl && it.value != 8'd0 && cmd[1]) pend |= iocit_pkg::Bit7Bit;
        b7_lvl = it.value != 8'd0;
        push_fielding();
      end
      default: ;
    endcase
    if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
  endtask

  // driver: bursts and gaps
  int gap = 0, burst = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict(iocit_pkg::item_t'({kind, address, value, pio_pins}));
        void'(items_q.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (items_q.size() > 0) begin
        in_valid <= 1'b1;
        kind <= items_q[0].kind;
        address <= items_q[0].address;
        value <= items_q[0].value;
        pio_pins <= items_q[0].pio_pins;
        if (burst == 0) begin
          burst <= $urandom_range(1, 12);
          gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        end else burst <= burst - 1;
      end else in_valid <= 1'b0;
    end
  end

  // monitor with its own stall pattern and one long hold-off
  always @(posedge clk) begin
    beat_t got, want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {read_data, int_event, int_request, int_vector, pio_write, pio_data, last};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
          end
        end
      end
      if (stall_count < 140) stall_count <= stall_count + 1;
      if (stall_count >= 60 && stall_count < 120) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(0, 9) < 3);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog > 5000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic iocit_pkg::item_t rand_item();
    iocit_pkg::item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.pio_pins = 8'($urandom);
    it.value = 8'($urandom);
    it.address = 4'($urandom);
    if (r < 25) it.kind = iocit_pkg::KIND_READ;
    else if (r < 55) begin
      it.kind = iocit_pkg::KIND_WRITE;
      case ($urandom_range(0, 5))
        0: it.address = iocit_pkg::AddrMask;
        1: it.address = iocit_pkg::AddrTimer0 + 4'($urandom_range(0, 4));
        2: begin
          it.address = iocit_pkg::AddrTimer0 + 4'($urandom_range(0, 4));
          it.value = 8'($urandom_range(0, 4));
        end
        3: begin
          it.address = iocit_pkg::AddrCommand;
          it.value = ($urandom_range(0, 7) == 0) ? it.value : it.value & 8'hfe;
        end
        default: ;
      endcase
    end else if (r < 80) it.kind = iocit_pkg::KIND_TICK;
    else if (r < 88) it.kind = iocit_pkg::KIND_SENSOR;
    else if (r < 96) it.kind = iocit_pkg::KIND_BIT7;
    else it.kind = 3'($urandom_range(5, 7));
    if ((it.kind == iocit_pkg::KIND_SENSOR || it.kind == iocit_pkg::KIND_BIT7) &&
        $urandom_range(0, 1))
      it.value = 8'd0;
    return it;
  endfunction

  task automatic add(logic [2:0] k, logic [3:0] a, logic [7:0] v, logic [7:0] p);
    items_q.push_back(iocit_pkg::item_t'({k, a, v, p}));
  endtask

  initial begin
    int wait_cycles;
    mask = '0; vlatch = '0; cmd = '0; sens_lvl = 1'b0;
    clear_soft();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed beats
    add(iocit_pkg::KIND_WRITE, iocit_pkg::AddrMask, 8'hff, 8'h00);
    for (int a = 0; a < 16; a++) add(iocit_pkg::KIND_READ, 4'(a), 8'h00, 8'hff);
    add(iocit_pkg::KIND_READ, iocit_pkg::AddrPins, 8'h00, 8'h00);
    add(iocit_pkg::KIND_WRITE, iocit_pkg::AddrPort, 8'hff, 8'h00);
    add(iocit_pkg::KIND_WRITE, iocit_pkg::AddrRate, 8'h5a, 8'h00);
    for (int t = 0; t < iocit_pkg::NumTimers; t++)
      add(iocit_pkg::KIND_WRITE, iocit_pkg::AddrTimer0 + 4'(t), 8'h01, 8'h00);
    add(iocit_pkg::KIND_TICK, 4'h0, 8'h00, 8'h00);            // all five expire on one tick
    add(iocit_pkg::KIND_WRITE, iocit_pkg::AddrTimer0, 8'h00, 8'h00);  // zero write fires once
    add(iocit_pkg::KIND_SENSOR, 4'h0, 8'hff, 8'h00);
    add(iocit_pkg::KIND_SENSOR, 4'h0, 8'h01, 8'h00);          // level held, no edge
    add(iocit_pkg::KIND_WRITE, iocit_pkg::AddrCommand, 8'h0e, 8'h00);  // int7 select on
    add(iocit_pkg::KIND_BIT7, 4'h0, 8'h80, 8'h00);
    add(iocit_pkg::KIND_WRITE, iocit_pkg::AddrTimer4, 8'h00, 8'h00);  // timer 4 gated off
    add(iocit_pkg::KIND_WRITE, iocit_pkg::AddrMask, 8'h00, 8'h00);
    add(iocit_pkg::KIND_SENSOR, 4'h0, 8'h00, 8'h00);          // nothing unmasked
    add(iocit_pkg::KIND_WRITE, iocit_pkg::AddrCommand, 8'hff, 8'h00);  // soft reset
    add(3'd7, 4'hf, 8'hff, 8'hff);
    @(posedge clk);
    for (int i = 0; i < 424; i++) items_q.push_back(rand_item());
    wait (items_q.size() == 0);
    @(posedge clk);
    wait_cycles = 0;
    while ((expected_q.size() != 0 || wait_cycles < 20) && wait_cycles < 4000) begin
      @(posedge clk);
      if (expected_q.size() == 0) wait_cycles++;
      else wait_cycles = (wait_cycles < 20) ? 0 : wait_cycles + 1;
    end
    if (errors == 0 && expected_q.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
